// File: hw/rtl/gffr_pkg.sv
`timescale 1ns / 1ps

package gffr_pkg;

  // Default map bounds
  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 32;

  // Field widths
  localparam int GRID_W   = 6;
  localparam int CELL_W   = 10;
  localparam int RECT_W   = 6;
  localparam int SLOT_W   = 11;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  // Register reset values
  localparam logic [GRID_W-1:0] GRID_COLS_RST = 6'd12;
  localparam logic [GRID_W-1:0] GRID_ROWS_RST = 6'd5;

  // Register indexes
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  // Item kinds carried on tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic item_wr;
    logic load_query;
    logic rd_issue;
    logic adv_cell;
    logic adv_cand;
    logic hit_set;
    logic out_load;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic query_reject;
    logic cell_busy;
    logic region_last;
    logic cand_last;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/gffr_ctrl.sv
`timescale 1ns / 1ps

module gffr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          s_tuser,
  output gffr_pkg::ctl_t ctl,
  input  gffr_pkg::sts_t sts
);

  gffr_pkg::state_t state;
  gffr_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gffr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      gffr_pkg::ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = gffr_pkg::ST_IDLE;
        end
      end
      gffr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == gffr_pkg::CMD_QUERY) begin
            ctl.load_query = 1'b1;
            state_next = sts.query_reject ? gffr_pkg::ST_FINISH : gffr_pkg::ST_READ;
          end else begin
            ctl.item_wr = 1'b1;
          end
        end
      end
      gffr_pkg::ST_READ: begin
        ctl.rd_issue = 1'b1;
        state_next   = gffr_pkg::ST_CHECK;
      end
      gffr_pkg::ST_CHECK: begin
        if (!sts.cell_busy) begin
          if (sts.region_last) begin
            ctl.hit_set = 1'b1;
            state_next  = gffr_pkg::ST_FINISH;
          end else begin
            ctl.adv_cell = 1'b1;
            state_next   = gffr_pkg::ST_READ;
          end
        end else if (sts.cand_last) begin
          state_next = gffr_pkg::ST_FINISH;
        end else begin
          ctl.adv_cand = 1'b1;
          state_next   = gffr_pkg::ST_READ;
        end
      end
      gffr_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = gffr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gffr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/gffr_datapath.sv
`timescale 1ns / 1ps

module gffr_datapath #(
  parameter int MAX_COLS = gffr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gffr_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_index,
  input  logic [gffr_pkg::GRID_W-1:0]     cfg_data,
  input  logic [gffr_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gffr_pkg::M_DATA_W-1:0]   m_tdata,
  input  gffr_pkg::ctl_t                  ctl,
  output gffr_pkg::sts_t                  sts
);

  localparam int MAP_CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int IW = ((AW > gffr_pkg::CELL_W) ? AW : gffr_pkg::CELL_W) + 1;
  localparam int PW = CW + RW + 1;

  // Configuration registers
  logic [gffr_pkg::GRID_W-1:0] grid_cols;
  logic [gffr_pkg::GRID_W-1:0] grid_rows;
  logic [CW-1:0] cols;
  logic [RW-1:0] rows;

  // Map and its ports
  logic          mem [MAP_CELLS];
  logic [AW-1:0] clr_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_bit;
  logic [AW-1:0] rd_addr;
  logic          rd_bit;

  // Item fields
  logic [gffr_pkg::CELL_W-1:0] cell_index;
  logic                        occupied;
  logic [gffr_pkg::RECT_W-1:0] rect_width;
  logic [gffr_pkg::RECT_W-1:0] rect_height;
  logic [IW-1:0]               widx;

  // Search registers
  logic [CW-1:0] qw;
  logic [RW-1:0] qh;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [CW-1:0] dc;
  logic [RW-1:0] dr;
  logic          hit;
  logic          row_wrap;
  logic          col_last;
  logic          dr_last;
  logic [PW-1:0] rd_full;
  logic [PW-1:0] slot_full;
  logic [gffr_pkg::SLOT_W-1:0] slot;

  assign cell_index  = s_tdata[9:0];
  assign occupied    = s_tdata[10];
  assign rect_width  = s_tdata[16:11];
  assign rect_height = s_tdata[22:17];

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= gffr_pkg::GRID_COLS_RST;
      grid_rows <= gffr_pkg::GRID_ROWS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == gffr_pkg::REG_GRID_COLS) begin
        grid_cols <= cfg_data;
      end else begin
        grid_rows <= cfg_data;
      end
    end
  end

  // Saturate grid size to the map bounds
  always_comb begin
    if (8'(grid_cols) > 8'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(grid_cols);
    end
    if (8'(grid_rows) > 8'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(grid_rows);
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Write port: sweep or cell write inside the map
  assign widx = IW'(cell_index);
  always_comb begin
    if (ctl.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_bit  = 1'b0;
    end else begin
      wr_en   = ctl.item_wr && (widx < IW'(MAP_CELLS));
      wr_addr = widx[AW-1:0];
      wr_bit  = occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  // Read port: covered cell (r0+dr)*cols + c0+dc
  assign rd_full = PW'(PW'(r0 + dr) * PW'(cols)) + PW'(c0) + PW'(dc);
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_bit <= mem[rd_addr];
    end
  end

  // Search counters
  assign dr_last  = (dr == qh - RW'(1));
  assign row_wrap = ((RW + 1)'(r0) + (RW + 1)'(qh) == (RW + 1)'(rows));
  assign col_last = ((CW + 1)'(c0) + (CW + 1)'(qw) == (CW + 1)'(cols));

  always_ff @(posedge clk) begin
    if (ctl.load_query) begin
      qw <= CW'(rect_width);
      qh <= RW'(rect_height);
      c0 <= '0;
      r0 <= '0;
      dc <= '0;
      dr <= '0;
    end else if (ctl.adv_cell) begin
      if (dr_last) begin
        dr <= '0;
        dc <= dc + CW'(1);
      end else begin
        dr <= dr + RW'(1);
      end
    end else if (ctl.adv_cand) begin
      dr <= '0;
      dc <= '0;
      if (row_wrap) begin
        r0 <= '0;
        c0 <= c0 + CW'(1);
      end else begin
        r0 <= r0 + RW'(1);
      end
    end
  end

  // Hold the hit flag until the next query clears it
  always_ff @(posedge clk) begin
    if (rst || ctl.load_query) begin
      hit <= 1'b0;
    end else if (ctl.hit_set) begin
      hit <= 1'b1;
    end
  end

  // Slot number col*rows+row+1
  assign slot_full = PW'(PW'(c0) * PW'(rows)) + PW'(r0) + PW'(1);
  assign slot      = hit ? gffr_pkg::SLOT_W'(slot_full) : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= gffr_pkg::M_DATA_W'(slot);
    end
  end

  // Status to the controller
  always_comb begin
    sts.clear_last   = (clr_cnt == AW'(MAP_CELLS - 1));
    sts.query_reject = (rect_width == '0) || (rect_height == '0) ||
                       (8'(rect_width) > 8'(cols)) || (8'(rect_height) > 8'(rows));
    sts.cell_busy    = rd_bit;
    sts.region_last  = dr_last && (dc == qw - CW'(1));
    sts.cand_last    = row_wrap && col_last;
    sts.out_free     = !m_tvalid || m_tready;
  end

endmodule

// File: hw/rtl/grid_first_fit_region_search_unit.sv
`timescale 1ns / 1ps
// Grid first-fit region search.
// Keeps an occupancy map of a grid of grid_cols by grid_rows cells.
// Input channel (s_t*): tuser selects a cell write or a region query.
//   A write sets or clears one cell, row-major address row*cols+col, and
//   gives no result.
// Output channel (m_t*): one slot number per query, col*rows+row+1 of the
//   first free top-left position (columns outer, rows inner), 0 if none.
// Configuration channel (cfg_*): register 0 grid_cols, register 1 grid_rows;
//   always ready; the user writes only while the block is idle (not enforced).
// Query scan: the scan reads one map bit at a time through the single map
//   read port and drops a candidate at its first occupied cell, so query
//   time is data dependent; a rejected query reads no bits.
// One item is worked at a time; the next item is taken once the controller
//   is back in idle, even while a result still waits in the output register.
// Reset clears all MAX_COLS*MAX_ROWS map cells in a sweep, during which
//   s_tready stays low; registers return to 12 columns and 5 rows.
// When the receiver stalls, the result holds in the output register and a
//   finished query waits until it is taken.

module grid_first_fit_region_search_unit #(
  parameter int MAX_COLS = gffr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gffr_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [gffr_pkg::GRID_W-1:0]   cfg_data,
  // Items in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_index[9:0], occupied[10], rect_width[16:11], rect_height[22:17]
  input  logic [gffr_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic                          s_tuser,
  // Results out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // slot_number[10:0]
  output logic [gffr_pkg::M_DATA_W-1:0] m_tdata
);

  gffr_pkg::ctl_t ctl;
  gffr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gffr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .ctl      (ctl),
    .sts      (sts)
  );

  gffr_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
